// ----- design/latency_stats_decaying_peak_macros.svh -----
// Assertion macros for the latency statistics block checker.
// Used by lsdp_checker; expects a clock named clk and a reset named rst in scope.
`ifndef LATENCY_STATS_DECAYING_PEAK_MACROS_SVH
`define LATENCY_STATS_DECAYING_PEAK_MACROS_SVH

// Property checked at every clock edge, reset included.
`define LSDP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked outside reset only.
`define LSDP_ASSERT_NRST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- design/lsdp_pkg.sv -----
// Shared types and constants for the latency statistics block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsdp_pkg;

  localparam int FRAC_BITS = 11;
  localparam int LAT_W     = 40;
  localparam int COUNT_W   = 32;
  localparam int SUM_W     = 64;
  localparam int TIME_W    = 32;

  localparam longint unsigned ONE_FX = 64'd1 << FRAC_BITS;

  // Decay factors, defined at 11 fraction bits and rescaled with rounding.
  localparam longint unsigned EXP_1_L  =
    (((64'd1884 << 16) * ONE_FX) / 64'd2048 + 64'd32768) >> 16;
  localparam longint unsigned EXP_5_L  =
    (((64'd2014 << 16) * ONE_FX) / 64'd2048 + 64'd32768) >> 16;
  localparam longint unsigned EXP_15_L =
    (((64'd2037 << 16) * ONE_FX) / 64'd2048 + 64'd32768) >> 16;

  localparam logic [FRAC_BITS-1:0] EXP_1  = EXP_1_L[FRAC_BITS-1:0];
  localparam logic [FRAC_BITS-1:0] EXP_5  = EXP_5_L[FRAC_BITS-1:0];
  localparam logic [FRAC_BITS-1:0] EXP_15 = EXP_15_L[FRAC_BITS-1:0];

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic              op;
    logic [LAT_W-1:0]  duration;
    logic [LAT_W-1:0]  extra_peak;
    logic [TIME_W-1:0] tick_time;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] interval_count;
    logic [SUM_W-1:0]   interval_total;
    logic [LAT_W-1:0]   interval_peak;
    logic [TIME_W-1:0]  peak_time;
    logic [LAT_W-1:0]   avg_short;
    logic [LAT_W-1:0]   avg_medium;
    logic [LAT_W-1:0]   avg_long;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
    logic [LAT_W-1:0]   peak;
  } acc_state_t;

endpackage

`default_nettype wire

// ----- design/lsdp_accum.sv -----
// Running sample count, latency total and interval peak.
// Depends on lsdp_pkg.
`default_nettype none

module lsdp_accum (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    sample_en,
  input  wire logic                    tick_en,
  input  wire logic [lsdp_pkg::LAT_W-1:0] duration,
  output lsdp_pkg::acc_state_t         state
);
  import lsdp_pkg::*;

  acc_state_t acc;
  acc_state_t acc_next;

  always_comb begin
    acc_next = acc;
    if (sample_en) begin
      acc_next.count = acc.count + COUNT_W'(1);
      acc_next.sum   = acc.sum + SUM_W'(duration);
      if (duration > acc.peak) begin
        acc_next.peak = duration;
      end
    end else if (tick_en) begin
      // count and total run on across ticks; only the peak restarts
      acc_next.peak = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  assign state = acc;

endmodule

`default_nettype wire

// ----- design/lsdp_decay.sv -----
// One decaying average register with its fixed-point update step.
// Depends on lsdp_pkg.
`default_nettype none

module lsdp_decay (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic [lsdp_pkg::FRAC_BITS-1:0] factor,
  input  wire logic [lsdp_pkg::LAT_W-1:0]     val,
  output logic      [lsdp_pkg::LAT_W-1:0]     avg_next
);
  import lsdp_pkg::*;

  localparam int P_W = LAT_W + FRAC_BITS;
  localparam int T_W = P_W + 1;

  logic [LAT_W-1:0]     avg;
  logic [FRAC_BITS-1:0] comp;
  logic [P_W-1:0]       prod_avg;
  logic [P_W-1:0]       prod_val;
  logic [T_W-1:0]       round_up;
  logic [T_W-1:0]       total;

  // 2^FRAC_BITS - factor, the weight of the new value
  assign comp     = ~factor + FRAC_BITS'(1);
  assign prod_avg = P_W'(avg) * P_W'(factor);
  assign prod_val = P_W'(val) * P_W'(comp);
  // round upwards when the average is rising
  assign round_up = (val >= avg) ? T_W'({FRAC_BITS{1'b1}}) : '0;
  assign total    = T_W'(prod_avg) + T_W'(prod_val) + round_up;
  assign avg_next = total[FRAC_BITS +: LAT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
    end else if (en) begin
      avg <= avg_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/latency_stats_decaying_peak.sv -----
// Latency statistics with decaying peak averages: top level.
// Depends on lsdp_pkg, lsdp_accum and lsdp_decay.
//
// Takes one item per cycle unless stalled as said below. A sample
// (op = OP_SAMPLE) bumps the running count, adds its duration to the
// running total and raises the interval peak; it gives no result. A
// tick (op = OP_TICK) takes the larger of the interval peak and
// extra_peak, folds it into the 1, 5 and 15 minute decaying averages,
// returns one result and restarts the interval peak. Count and total
// keep running across ticks and wrap. An accepted item is held in the
// input register and executed from there; executing a tick loads the
// result register, which raises result_valid. Sustained rate is one
// item per cycle, set by the accumulator and average registers updating
// on every executed item. Only a tick waiting for an untaken result
// stalls the input; samples keep flowing while a result waits. No
// clearing pass: the block is ready straight after reset.
`default_nettype none

module latency_stats_decaying_peak (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire lsdp_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output lsdp_pkg::result_t      result
);
  import lsdp_pkg::*;

  // input register
  logic  s1_valid;
  item_t s1_item;

  // execute control
  logic out_free;
  logic exec_go;
  logic sample_en;
  logic tick_en;

  acc_state_t       acc;
  logic [LAT_W-1:0] peak_mix;
  logic [LAT_W-1:0] short_next;
  logic [LAT_W-1:0] medium_next;
  logic [LAT_W-1:0] long_next;
  result_t          result_next;

  // the result register can take a new result this cycle
  assign out_free  = !result_valid || result_ready;
  // samples never need the result register
  assign exec_go   = s1_valid && ((s1_item.op == OP_SAMPLE) || out_free);
  assign item_ready = !s1_valid || exec_go;
  assign sample_en = exec_go && (s1_item.op == OP_SAMPLE);
  assign tick_en   = exec_go && (s1_item.op == OP_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  lsdp_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .sample_en (sample_en),
    .tick_en   (tick_en),
    .duration  (s1_item.duration),
    .state     (acc)
  );

  // value folded into the averages: interval peak or the tick's own peak
  assign peak_mix = (acc.peak > s1_item.extra_peak) ? acc.peak : s1_item.extra_peak;

  lsdp_decay u_decay_short (
    .clk      (clk),
    .rst      (rst),
    .en       (tick_en),
    .factor   (EXP_1),
    .val      (peak_mix),
    .avg_next (short_next)
  );

  lsdp_decay u_decay_medium (
    .clk      (clk),
    .rst      (rst),
    .en       (tick_en),
    .factor   (EXP_5),
    .val      (peak_mix),
    .avg_next (medium_next)
  );

  lsdp_decay u_decay_long (
    .clk      (clk),
    .rst      (rst),
    .en       (tick_en),
    .factor   (EXP_15),
    .val      (peak_mix),
    .avg_next (long_next)
  );

  always_comb begin
    result_next.interval_count = acc.count;
    result_next.interval_total = acc.sum;
    // reported peak is the sample peak only, before the restart
    result_next.interval_peak  = acc.peak;
    result_next.peak_time      = s1_item.tick_time;
    result_next.avg_short      = short_next;
    result_next.avg_medium     = medium_next;
    result_next.avg_long       = long_next;
  end

  // result register: loaded by a tick, emptied by a transfer out
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tick_en) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/lsdp_checker.sv -----
// Port-level checks for the latency statistics block, bound to the top level.
// Depends on lsdp_pkg and latency_stats_decaying_peak_macros.svh.
`default_nettype none

`include "latency_stats_decaying_peak_macros.svh"

module lsdp_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                item_ready,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire lsdp_pkg::result_t   result
);
  import lsdp_pkg::*;

  `LSDP_ASSERT(a_reset_empty, rst |=> !result_valid, "result valid after reset")
  `LSDP_ASSERT_NRST(a_ready_when_empty, !result_valid |-> item_ready, "input stalled with no result waiting")
  `LSDP_ASSERT_NRST(a_valid_held, result_valid && !result_ready |=> result_valid, "result dropped before transfer")
  `LSDP_ASSERT_NRST(a_payload_held, result_valid && !result_ready |=> $stable(result), "result changed while stalled")

endmodule

bind latency_stats_decaying_peak lsdp_checker u_lsdp_checker (.*);

`default_nettype wire
